// ===== rtl/core/msafd_pkg.sv =====
// ----------------------------------------------------------------------------
// msafd_pkg
// Shared constants, codes and types of the multi-square arm/fire debouncer.
// ----------------------------------------------------------------------------
package msafd_pkg;

  localparam int unsigned MAX_OPTIONS = 7;
  localparam int unsigned BOARD_ROWS  = 8;
  localparam int unsigned CHANNELS    = MAX_OPTIONS + 1;
  localparam int unsigned CH_W        = 3;
  localparam int unsigned SQ_W        = 7;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned OCC_W       = 64;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DATA_W      = 64;

  typedef enum logic [2:0] {
    REG_STABLE  = 3'd0,
    REG_OPT_CNT = 3'd1,
    REG_OPT_SQ  = 3'd2,
    REG_OPT_ID  = 3'd3,
    REG_BACK_EN = 3'd4,
    REG_BACK_SQ = 3'd5,
    REG_FLIP    = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_POLL  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CNT_W-1:0]             stable_cycles;
    logic [CH_W-1:0]              option_count;
    logic [SQ_W*MAX_OPTIONS-1:0]  option_squares;
    logic [ID_W*MAX_OPTIONS-1:0]  option_ids;
    logic                         back_enable;
    logic [SQ_W-1:0]              back_square;
    logic                         flip;
  } cfg_t;

  // per-cell scan status
  typedef struct packed {
    logic tok;   // cell holds the scan token
    logic pass;  // token moves on to the next cell
    logic fire;  // channel fired this cycle
  } cell_stat_t;

endpackage

// ===== rtl/core/msafd_cell.sv =====
// ----------------------------------------------------------------------------
// msafd_cell
// One debouncer channel; updates when the scan token reaches it.
// ----------------------------------------------------------------------------
module msafd_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 tok_i,
  input  logic                                 clear_i,
  input  logic [msafd_pkg::OCC_W-1:0]          occ_i,
  input  logic [msafd_pkg::SQ_W-1:0]           square_i,
  input  logic                                 flip_i,
  input  logic [msafd_pkg::CNT_W-1:0]          stable_i,
  input  logic                                 active_i,
  output msafd_pkg::cell_stat_t                stat_o
);
  import msafd_pkg::*;

  logic             tok_q;
  logic [CNT_W-1:0] empty_q, empty_d;
  logic [CNT_W-1:0] occd_q, occd_d;
  logic             armed_q, armed_d;
  logic             latched_q, latched_d;
  logic [3:0]       row_w;
  logic             hit;
  logic             fire;

  // square lookup; rows past the board (after flip) read as empty
  always_comb begin
    row_w = {1'b0, square_i[5:3]};
    if (flip_i) begin
      row_w = 4'(BOARD_ROWS - 1) - row_w;
    end
    hit = !square_i[6] && (row_w < 4'(BOARD_ROWS))
          && occ_i[{row_w[2:0], square_i[2:0]}];
  end

  always_comb begin
    empty_d   = empty_q;
    occd_d    = occd_q;
    armed_d   = armed_q;
    latched_d = latched_q;
    fire      = 1'b0;
    if (tok_q && active_i) begin
      if (!hit) begin
        if (empty_q < stable_i) begin
          empty_d = empty_q + 8'd1;
        end
        occd_d    = '0;
        latched_d = 1'b0;
        if (empty_d >= stable_i) begin
          armed_d = 1'b1;
        end
      end else begin
        empty_d = '0;
        if (!armed_q || latched_q) begin
          occd_d = '0;
        end else begin
          if (occd_q < stable_i) begin
            occd_d = occd_q + 8'd1;
          end
          if (occd_d >= stable_i) begin
            armed_d   = 1'b0;
            latched_d = 1'b1;
            fire      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= 1'b0;
      empty_q   <= '0;
      occd_q    <= '0;
      armed_q   <= 1'b0;
      latched_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      if (clear_i) begin
        empty_q   <= '0;
        occd_q    <= '0;
        armed_q   <= 1'b0;
        latched_q <= 1'b0;
      end else begin
        empty_q   <= empty_d;
        occd_q    <= occd_d;
        armed_q   <= armed_d;
        latched_q <= latched_d;
      end
    end
  end

  assign stat_o.tok  = tok_q;
  assign stat_o.pass = tok_q && active_i && !fire;
  assign stat_o.fire = fire;

endmodule

// ===== rtl/core/msafd_cfg.sv =====
// ----------------------------------------------------------------------------
// msafd_cfg
// APB register file holding the debouncer configuration.
// ----------------------------------------------------------------------------
module msafd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [msafd_pkg::ADDR_W-1:0]       paddr,
  input  logic [msafd_pkg::DATA_W-1:0]       pwdata,
  output logic [msafd_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  output msafd_pkg::cfg_t                    cfg_o
);
  import msafd_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             wr_en;
  reg_idx_e         idx;
  logic [CNT_W-1:0] stable_w;
  logic [CH_W-1:0]  cnt_w;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);

  always_comb begin
    stable_w = pwdata[CNT_W-1:0];
    if (stable_w == '0) begin
      stable_w = 8'd1;
    end
    cnt_w = pwdata[CH_W-1:0];
    if (5'(cnt_w) > 5'(MAX_OPTIONS)) begin
      cnt_w = CH_W'(MAX_OPTIONS);
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_STABLE:  cfg_d.stable_cycles  = stable_w;
        REG_OPT_CNT: cfg_d.option_count   = cnt_w;
        REG_OPT_SQ:  cfg_d.option_squares = pwdata[SQ_W*MAX_OPTIONS-1:0];
        REG_OPT_ID:  cfg_d.option_ids     = pwdata[ID_W*MAX_OPTIONS-1:0];
        REG_BACK_EN: cfg_d.back_enable    = pwdata[0];
        REG_BACK_SQ: cfg_d.back_square    = pwdata[SQ_W-1:0];
        REG_FLIP:    cfg_d.flip           = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STABLE:  prdata = DATA_W'(cfg_q.stable_cycles);
      REG_OPT_CNT: prdata = DATA_W'(cfg_q.option_count);
      REG_OPT_SQ:  prdata = DATA_W'(cfg_q.option_squares);
      REG_OPT_ID:  prdata = DATA_W'(cfg_q.option_ids);
      REG_BACK_EN: prdata = DATA_W'(cfg_q.back_enable);
      REG_BACK_SQ: prdata = DATA_W'(cfg_q.back_square);
      REG_FLIP:    prdata = DATA_W'(cfg_q.flip);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{stable_cycles: CNT_W'(1), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/multi_square_arm_fire_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// multi_square_arm_fire_debouncer_top
// Multi-channel arm/fire debouncer over a 64-square occupancy map.
// ----------------------------------------------------------------------------
// Each input transaction is either a poll (tuser = 0, tdata = occupancy map)
// or a clear (tuser = 1). Every transaction returns exactly one result
// transaction. The channels sit in a row of eight debouncer cells; a poll
// injects a scan token into cell 0 and the token walks one cell per clock.
// The result of a poll is registered once its scan ends, and the next
// transaction is taken only after that. The scan stops at the first cell
// that fires, at the first unused channel or at the last cell. A clear
// resets all cells and its result is registered at the accepting edge
// itself. One transaction is worked on at a time, while a two-deep output
// buffer holds results the master side has not yet taken. No clearing pass
// after reset. Configuration goes through APB at byte address 8*index and
// must be written only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module multi_square_arm_fire_debouncer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [msafd_pkg::OCC_W-1:0]       s_axis_tdata,  // [63:0] occupancy
  input  logic                              s_axis_tuser,  // [0] command
  // master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] fired, [1] is_back, [9:2] option_id, [12:10] channel_index, rest 0
  output logic [msafd_pkg::OUT_W-1:0]       m_axis_tdata,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msafd_pkg::ADDR_W-1:0]      paddr,
  input  logic [msafd_pkg::DATA_W-1:0]      pwdata,
  output logic [msafd_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);
  import msafd_pkg::*;

  cfg_t              cfg;
  logic              in_acc, start, clr;
  logic [OCC_W-1:0]  occ_q;
  logic              busy_q, busy_d;

  // per-channel wiring
  logic [SQ_W-1:0]   sq_w   [CHANNELS];
  logic [ID_W-1:0]   id_w   [CHANNELS];
  logic              back_w [CHANNELS];
  logic              act_w  [CHANNELS];
  logic              tok_in [CHANNELS];
  cell_stat_t        stat   [CHANNELS];
  logic [CHANNELS-1:0] tok_vec;

  logic              done;
  logic [OUT_W-1:0]  res_word;
  logic              new_vld;
  logic [OUT_W-1:0]  new_word;

  // output buffer: out stage plus one skid entry
  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_q, out_d;
  logic              skid_vld_q, skid_vld_d;
  logic [OUT_W-1:0]  skid_q, skid_d;
  logic              out_free;

  msafd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !busy_q && !skid_vld_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign start  = in_acc && (cmd_e'(s_axis_tuser) == CMD_POLL);
  assign clr    = in_acc && (cmd_e'(s_axis_tuser) == CMD_CLEAR);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      occ_q <= s_axis_tdata;
    end
  end

  // channel i is the back channel when it sits right after the options
  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    assign back_w[i] = cfg.back_enable && (CH_W'(i) == cfg.option_count);
    assign act_w[i]  = (4'(i) < (4'(cfg.option_count) + 4'(cfg.back_enable)));
    if (i < MAX_OPTIONS) begin : g_opt
      assign sq_w[i] = back_w[i] ? cfg.back_square : cfg.option_squares[i*SQ_W +: SQ_W];
      assign id_w[i] = back_w[i] ? '0 : cfg.option_ids[i*ID_W +: ID_W];
    end else begin : g_back
      assign sq_w[i] = back_w[i] ? cfg.back_square : '0;
      assign id_w[i] = '0;
    end
    if (i == 0) begin : g_head
      assign tok_in[i] = start;
    end else begin : g_link
      assign tok_in[i] = stat[i-1].pass;
    end
    assign tok_vec[i] = stat[i].tok;

    msafd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_in[i]),
      .clear_i  (clr),
      .occ_i    (occ_q),
      .square_i (sq_w[i]),
      .flip_i   (cfg.flip),
      .stable_i (cfg.stable_cycles),
      .active_i (act_w[i]),
      .stat_o   (stat[i])
    );
  end

  // scan ends where the token stops: a fire, an unused channel, or the last cell
  always_comb begin
    done     = stat[CHANNELS-1].tok;
    res_word = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < CHANNELS - 1) begin
        done = done | (stat[i].tok & ~stat[i].pass);
      end
      if (stat[i].fire) begin
        res_word = res_word | {3'b000, CH_W'(i), id_w[i], back_w[i], 1'b1};
      end
    end
  end

  assign new_vld  = clr || (busy_q && done);
  assign new_word = clr ? '0 : res_word;

  always_comb begin
    busy_d = busy_q;
    if (start) begin
      busy_d = 1'b1;
    end else if (busy_q && done) begin
      busy_d = 1'b0;
    end
  end

  // results leave in order: skid entry is always older than a new result
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = new_vld;
        skid_d     = new_word;
      end else begin
        out_vld_d = new_vld;
        out_d     = new_word;
      end
    end else if (new_vld) begin
      skid_vld_d = 1'b1;
      skid_d     = new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---- assertions ----
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one scan token in the chain");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|tok_vec) |-> busy_q)
    else $error("scan token present while idle");

  a_start_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> stat[0].tok)
    else $error("poll did not enter the first cell");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && done) |=> !busy_q)
    else $error("scan end did not release the block");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output stage");

endmodule

// ===== tb/multi_square_arm_fire_debouncer_top_tb.sv =====
// ----------------------------------------------------------------------------
// multi_square_arm_fire_debouncer_top_tb
// Self-checking bench for the multi-square arm/fire debouncer.
// ----------------------------------------------------------------------------
// A directed table runs first. It covers the zero-channel poll, the clear
// command, the fire that ends the scan (zero id included), the back channel,
// the off-board square, the row flip and a written stable count of zero.
// Random phases follow, each with its own register setting; stable counts
// of 1 and 255 are among them. Occupancy is held in runs near the stable
// count, so channels really arm and fire. Each poll result is predicted by
// a behavioral copy of the debouncer bank and compared field by field.
// Both stream sides idle in random bursts; the last phase runs without any.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_square_arm_fire_debouncer_top_tb;
  import msafd_pkg::*;

  // result word as it sits in m_axis_tdata, lowest bit last
  typedef struct packed {
    logic [2:0] pad;
    logic [2:0] channel_index;
    logic [7:0] option_id;
    logic       is_back;
    logic       fired;
  } sel_result_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

  // one directed step: a register write or a stream transaction
  typedef struct {
    row_kind_e   kind;
    reg_idx_e    ridx;
    logic [63:0] rval;
    cmd_e        cmd;
    logic [63:0] occ;
    bit          known;  // res holds the typed-in answer
    sel_result_t res;
  } dir_row_t;

  localparam sel_result_t NO_SEL   = '0;
  localparam logic [63:0] FULL_MAP = '1;
  localparam logic [63:0] TOP_SQ   = 64'h8000_0000_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OCC_W-1:0]      s_axis_tdata = '0;  // [63:0] occupancy
  logic                  s_axis_tuser = 1'b0;  // [0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] fired, [1] is_back, [9:2] option_id, [12:10] channel_index
  logic [OUT_W-1:0]      m_axis_tdata;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  // bench-side copy of the registers and the per-channel debouncers
  cfg_t        board_cfg;
  logic [7:0]  empty_run [CHANNELS] = '{default: '0};
  logic [7:0]  full_run  [CHANNELS] = '{default: '0};
  logic        armed     [CHANNELS] = '{default: 1'b0};
  logic        latched   [CHANNELS] = '{default: 1'b0};

  sel_result_t pending_sel [$];  // predicted results, oldest first
  int          mismatch_cnt = 0;
  int          idle_pct = 0;     // chance in percent that a side idles

  dir_row_t    dir_tab [31];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  multi_square_arm_fire_debouncer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Debouncer bank model
  // ---------------------------------------------------------------------------

  // channels in use: options first, then the back channel if enabled
  function automatic int channel_total();
    int n;
    n = board_cfg.option_count;
    if (n > MAX_OPTIONS) n = MAX_OPTIONS;
    return n + board_cfg.back_enable;
  endfunction

  function automatic logic [6:0] channel_square(int ch);
    if (board_cfg.back_enable && ch == channel_total() - 1) return board_cfg.back_square;
    return board_cfg.option_squares[SQ_W*ch +: SQ_W];
  endfunction

  // occupancy bit a square maps to, -1 when off the board
  function automatic int square_bit(logic [6:0] sq);
    int row;
    if (sq[6]) return -1;
    row = sq[5:3];
    if (board_cfg.flip) row = int'(BOARD_ROWS) - 1 - row;
    if (row < 0 || row >= int'(BOARD_ROWS)) return -1;
    return row * 8 + sq[2:0];
  endfunction

  // one sample into a channel's debouncer; 1 when it fires
  function automatic bit debounce_step(int ch, bit occupied);
    logic [7:0] lim;
    lim = board_cfg.stable_cycles;
    if (!occupied) begin
      if (empty_run[ch] < lim) empty_run[ch]++;
      full_run[ch] = '0;
      latched[ch]  = 1'b0;
      if (empty_run[ch] >= lim) armed[ch] = 1'b1;
      return 1'b0;
    end
    empty_run[ch] = '0;
    if (!armed[ch] || latched[ch]) begin
      full_run[ch] = '0;
      return 1'b0;
    end
    if (full_run[ch] < lim) full_run[ch]++;
    if (full_run[ch] >= lim) begin
      armed[ch]   = 1'b0;
      latched[ch] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic sel_result_t predict_selection(cmd_e cmd, logic [63:0] occ);
    sel_result_t r;
    int          n;
    int          b;
    bit          back_ch;
    r = NO_SEL;
    if (cmd == CMD_CLEAR) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        empty_run[ch] = '0;
        full_run[ch]  = '0;
        armed[ch]     = 1'b0;
        latched[ch]   = 1'b0;
      end
      return r;
    end
    n = channel_total();
    // scan stops at the first channel that fires
    for (int ch = 0; ch < n; ch++) begin
      b = square_bit(channel_square(ch));
      if (debounce_step(ch, (b >= 0) && occ[b])) begin
        back_ch         = board_cfg.back_enable && ch == n - 1;
        r.fired         = 1'b1;
        r.is_back       = back_ch;
        r.option_id     = back_ch ? 8'd0 : board_cfg.option_ids[ID_W*ch +: ID_W];
        r.channel_index = ch[2:0];
        return r;
      end
    end
    return r;
  endfunction

  function automatic sel_result_t sel_of(bit f, bit bk, logic [7:0] id, logic [2:0] ch);
    sel_result_t r;
    r = '{pad: 3'd0, channel_index: ch, option_id: id, is_back: bk, fired: f};
    return r;
  endfunction

  // random square, off the board about one time in eight
  function automatic logic [6:0] rand_square();
    return {($urandom_range(0, 7) == 0), 6'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------------

  // APB write: setup, access, then idle, so back-to-back writes
  // never lower and raise psel in the same step
  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STABLE:  board_cfg.stable_cycles  = (v[7:0] == 8'd0) ? 8'd1 : v[7:0];
      REG_OPT_CNT: board_cfg.option_count   = (v[2:0] > MAX_OPTIONS) ? 3'(MAX_OPTIONS) : v[2:0];
      REG_OPT_SQ:  board_cfg.option_squares = v[SQ_W*MAX_OPTIONS-1:0];
      REG_OPT_ID:  board_cfg.option_ids     = v[ID_W*MAX_OPTIONS-1:0];
      REG_BACK_EN: board_cfg.back_enable    = v[0];
      REG_BACK_SQ: board_cfg.back_square    = v[SQ_W-1:0];
      REG_FLIP:    board_cfg.flip           = v[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one stream transaction; the prediction is made at the accepting edge
  task automatic send_item(cmd_e cmd, logic [63:0] occ, bit known, sel_result_t res);
    sel_result_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= occ;
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_selection(cmd, occ);
    pending_sel.push_back(known ? res : p);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold the input side until every predicted result has come back
  task automatic drain_results(int settle);
    s_axis_tvalid <= 1'b0;
    while (pending_sel.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the field-by-field compare
  // ---------------------------------------------------------------------------
  initial begin : result_monitor
    sel_result_t got;
    sel_result_t want;
    int          stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = sel_result_t'(m_axis_tdata);
        if (pending_sel.size() == 0) begin
          $error("result transaction with nothing pending: tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = pending_sel.pop_front();
          if (got.fired !== want.fired) begin
            $error("fired: expected %0d, actual %0d", want.fired, got.fired);
            mismatch_cnt++;
          end
          if (got.is_back !== want.is_back) begin
            $error("is_back: expected %0d, actual %0d", want.is_back, got.is_back);
            mismatch_cnt++;
          end
          if (got.option_id !== want.option_id) begin
            $error("option_id: expected %0d, actual %0d", want.option_id, got.option_id);
            mismatch_cnt++;
          end
          if (got.channel_index !== want.channel_index) begin
            $error("channel_index: expected %0d, actual %0d",
                   want.channel_index, got.channel_index);
            mismatch_cnt++;
          end
          if (got.pad !== want.pad) begin
            $error("tdata[15:13]: expected %0d, actual %0d", want.pad, got.pad);
            mismatch_cnt++;
          end
        end
      end
      // stall bursts, started at random
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] sq_word;
    logic [63:0] held;      // occupancy of the watched squares, held in runs
    logic [63:0] watch_mask;
    logic [63:0] occ;
    logic [7:0]  stable_val;
    int          items;
    int          run_left;
    int          bit_no;
    int          lim;
    int          clear_odds;
    int          noise_odds;
    cmd_e        cmd;

    board_cfg               = '0;
    board_cfg.stable_cycles = 8'd1;

    dir_tab = '{
      // no channels configured: a full board answers nothing
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b1, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_CLEAR, FULL_MAP, 1'b1, NO_SEL},
      // two options (a1 with id 0xFF, h8 with id 0), back square off the board
      '{ROW_REG, REG_OPT_CNT, 64'd2, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_OPT_SQ, 64'h1F80, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_OPT_ID, 64'h00FF, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_BACK_EN, 64'd1, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_BACK_SQ, 64'h40, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, 64'd0, 1'b1, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b1, sel_of(1, 0, 8'hFF, 3'd0)},
      // channel 1 was skipped above, so it fires now, id 0 included
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b1, sel_of(1, 0, 8'h00, 3'd1)},
      // both latched, off-board back square reads empty
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b1, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, 64'd0, 1'b1, NO_SEL},
      // flipped board: back square row 0 col 7 looks at bit 63
      '{ROW_REG, REG_BACK_SQ, 64'd7, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_FLIP, 64'd1, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, TOP_SQ, 1'b1, sel_of(1, 1, 8'h00, 3'd2)},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_CLEAR, 64'd0, 1'b1, NO_SEL},
      // cleared channels are disarmed
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, TOP_SQ, 1'b1, NO_SEL},
      // stable count written as 0 reads as 1; all seven options plus back
      '{ROW_REG, REG_STABLE, 64'd0, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_OPT_CNT, 64'd7, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_OPT_SQ, {15'd0, 7'd54, 7'd45, 7'd36, 7'd27, 7'd18, 7'd9, 7'd0},
        CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_REG, REG_OPT_ID, 64'h0070_6050_4030_2010, CMD_POLL, 64'd0, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, 64'd0, 1'b1, NO_SEL},
      // full board: one channel fires per poll, back channel last at index 7
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_POLL, FULL_MAP, 1'b0, NO_SEL},
      '{ROW_ITEM, REG_STABLE, 64'd0, CMD_CLEAR, FULL_MAP, 1'b1, NO_SEL}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; register rows wait for the block to go idle
    idle_pct = 20;
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_REG) begin
        drain_results(10);
        write_reg(dir_tab[r].ridx, dir_tab[r].rval);
      end else begin
        send_item(dir_tab[r].cmd, dir_tab[r].occ, dir_tab[r].known, dir_tab[r].res);
      end
    end

    // random phases; debouncer state carries over between settings,
    // so lowering the stable count meets counters already above it
    for (int ph = 0; ph < 6; ph++) begin
      drain_results(10);
      case (ph)
        0: begin stable_val = 8'd1;   items = 200; idle_pct = 15; end
        1: begin stable_val = 8'd3;   items = 200; idle_pct = 30; end
        2: begin stable_val = 8'd255; items = 580; idle_pct = 5;  end
        3: begin stable_val = 8'd0;   items = 60;  idle_pct = 20; end
        4: begin stable_val = 8'd4;   items = 150; idle_pct = 20; end
        default: begin stable_val = 8'd2; items = 150; idle_pct = 0; end
      endcase
      // long runs at the top stable count must not be broken up
      clear_odds = (ph == 2) ? 1000 : 40;
      noise_odds = (ph == 2) ? 0 : 20;

      sq_word = '0;
      for (int k = 0; k < MAX_OPTIONS; k++) sq_word[SQ_W*k +: SQ_W] = rand_square();
      if (ph == 3) sq_word = FULL_MAP;  // every option square off the board

      write_reg(REG_STABLE, 64'(stable_val));
      if (ph == 2) write_reg(REG_OPT_CNT, 64'($urandom_range(1, 2)));
      else if (ph == 3 || ph == 4) write_reg(REG_OPT_CNT, 64'd7);
      else write_reg(REG_OPT_CNT, 64'($urandom_range(0, 7)));
      write_reg(REG_OPT_SQ, sq_word);
      write_reg(REG_OPT_ID, (ph == 3) ? FULL_MAP : {$urandom, $urandom});
      write_reg(REG_BACK_EN, (ph == 4) ? 64'd1 : 64'($urandom_range(0, 1)));
      write_reg(REG_BACK_SQ, 64'(rand_square()));
      write_reg(REG_FLIP, 64'($urandom_range(0, 1)));

      watch_mask = '0;
      for (int ch = 0; ch < channel_total(); ch++) begin
        bit_no = square_bit(channel_square(ch));
        if (bit_no >= 0) watch_mask[bit_no] = 1'b1;
      end
      held     = {$urandom, $urandom};
      run_left = 0;
      lim      = board_cfg.stable_cycles;

      for (int i = 0; i < items; i++) begin
        // new run: flip about half the watched squares, length near the
        // stable count so channels both arm and fire
        if (run_left == 0) begin
          for (int ch = 0; ch < channel_total(); ch++) begin
            bit_no = square_bit(channel_square(ch));
            if (bit_no >= 0 && $urandom_range(0, 1) == 1) held[bit_no] = ~held[bit_no];
          end
          run_left = $urandom_range(0, 1) ? $urandom_range(1, lim)
                                          : $urandom_range(lim, lim + 2);
        end
        run_left--;
        occ = (held & watch_mask) | ({$urandom, $urandom} & ~watch_mask);
        if (noise_odds != 0 && $urandom_range(1, noise_odds) == 1) occ = {$urandom, $urandom};
        cmd = ($urandom_range(1, clear_odds) == 1) ? CMD_CLEAR : CMD_POLL;
        send_item(cmd, occ, 1'b0, NO_SEL);
        // hold off mid-phase until every result is back
        if (ph == 1 && i == 100) drain_results(0);
      end
    end

    drain_results(20);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
